FILE: design/dd_pkg.sv
// Shared types, constants and calendar helpers for the date difference / add days block.
// Depends on nothing; every other file in design/ imports it.
package dd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 20;
    localparam int DIFF_W  = 22;
    localparam int ACC_W   = 24;

    localparam int DAYS_YEAR  = 365;
    localparam int DAYS_LEAP  = 366;
    localparam int DAYS_4Y    = 1461;
    localparam int DAYS_40Y   = 14610;
    localparam int DAYS_400Y  = 146100;
    localparam int JUMP_W     = 18;

    localparam logic [DIFF_W-1:0] DIFF_MAX = '1;

    typedef struct packed {
        logic                mode;
        logic [DAY_W-1:0]    first_day;
        logic [MONTH_W-1:0]  first_month;
        logic [YEAR_W-1:0]   first_year;
        logic [DAY_W-1:0]    second_day;
        logic [MONTH_W-1:0]  second_month;
        logic [YEAR_W-1:0]   second_year;
        logic [COUNT_W-1:0]  day_count;
    } in_t;

    typedef struct packed {
        logic [DIFF_W-1:0]   day_difference;
        logic [DAY_W-1:0]    result_day;
        logic [MONTH_W-1:0]  result_month;
        logic [YEAR_W-1:0]   result_year;
        logic                date_error;
        logic                year_overflow;
    } out_t;

    typedef struct packed {
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ACC_W-1:0] sum;
        logic             borrow;
    } alu_rsp_t;

    function automatic logic [DAY_W-1:0] days_in_month(logic [MONTH_W-1:0] m, logic leap);
        logic [DAY_W-1:0] n;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:                                       n = leap ? 5'd29 : 5'd28;
            default:                                    n = 5'd0;
        endcase
        return n;
    endfunction

    // Days in the year before the first of month m.
    function automatic logic [8:0] days_before_month(logic [MONTH_W-1:0] m, logic leap);
        logic [8:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        if (leap && m > 4'd2)
            n = n + 9'd1;
        return n;
    endfunction

endpackage

FILE: design/date_difference_and_add_days_core.sv
// Top level of the calendar date block: sequencer, operand selection and result register.
// Depends on dd_pkg, dd_check and dd_alu.
//
// One request word is taken when start is high and busy is low; the result word appears on
// result for exactly one cycle with done high, and the receiver cannot hold it off. Every
// year divisible by 4 is a leap year. In mode 0 the block forms the signed difference of the
// two day numbers by accumulating eight terms (year*365, leap days, days before the month,
// day of month, for A then B) through one shared add/subtract unit, then takes the magnitude
// and saturates it. In mode 1 the same unit walks date A forward: month steps up to the next
// 1 January, then jumps of 400, 40, 4 and 1 years while the remaining count allows and the
// year stays in range, then month steps to the final day. One unit operation per cycle, so
// the length of a mode 1 request depends on the start date and the count. busy is low again
// in the cycle that shows done, so a new word may be accepted while a result is on the port.
module date_difference_and_add_days_core #(
    parameter int MAX_YEAR     = 9999,
    parameter int DEFAULT_YEAR = 2002
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  dd_pkg::in_t  req,
    output logic         busy,
    output logic         done,
    output dd_pkg::out_t result
);
    import dd_pkg::*;

    // The walking year never passes the larger of MAX_YEAR and DEFAULT_YEAR by more than 400.
    localparam int YTOP = ((MAX_YEAR > DEFAULT_YEAR) ? MAX_YEAR : DEFAULT_YEAR) + 401;
    localparam int YR_W = $clog2(YTOP + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIFF = 4'b0010,
        ST_ADD  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    typedef enum logic [4:0] {
        LV_400   = 5'b00001,
        LV_40    = 5'b00010,
        LV_4     = 5'b00100,
        LV_1     = 5'b01000,
        LV_MONTH = 5'b10000
    } level_t;

    state_t                state_reg, state_next;
    logic                  done_reg, done_next;
    out_t                  result_reg, result_next;

    level_t                level_reg, level_next;
    logic                  mode_reg, mode_next;
    logic                  err_reg, err_next;
    logic                  ovf_reg, ovf_next;
    logic [DAY_W-1:0]      d_reg, d_next;
    logic [MONTH_W-1:0]    m_reg, m_next;
    logic [YR_W-1:0]       y_reg, y_next;
    logic [DAY_W-1:0]      bd_reg, bd_next;
    logic [MONTH_W-1:0]    bm_reg, bm_next;
    logic [YEAR_W-1:0]     by_reg, by_next;
    logic [COUNT_W-1:0]    left_reg, left_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [2:0]            step_reg, step_next;

    logic [DAY_W-1:0]      a_day, b_day;
    logic [MONTH_W-1:0]    a_month, b_month;
    logic [YEAR_W-1:0]     a_year, b_year;
    logic                  a_bad, b_bad;

    alu_req_t              alu_req;
    alu_rsp_t              alu_rsp;

    logic                  accept;
    logic                  at_jan1;
    logic                  leap;
    logic [DAY_W-1:0]      month_len;
    logic [5:0]            month_room;
    logic [JUMP_W-1:0]     jump_days;
    logic [8:0]            jump_years;
    logic [YR_W-1:0]       y_sum;
    logic                  y_over;
    logic [ACC_W-1:0]      term;
    logic [DAY_W-1:0]      t_day;
    logic [MONTH_W-1:0]    t_month;
    logic [YR_W-1:0]       t_year;
    logic [ACC_W-1:0]      magnitude;

    dd_check #(.MAX_YEAR(MAX_YEAR), .DEFAULT_YEAR(DEFAULT_YEAR)) u_check_a (
        .day       (req.first_day),
        .month     (req.first_month),
        .year      (req.first_year),
        .fix_day   (a_day),
        .fix_month (a_month),
        .fix_year  (a_year),
        .bad       (a_bad)
    );

    dd_check #(.MAX_YEAR(MAX_YEAR), .DEFAULT_YEAR(DEFAULT_YEAR)) u_check_b (
        .day       (req.second_day),
        .month     (req.second_month),
        .year      (req.second_year),
        .fix_day   (b_day),
        .fix_month (b_month),
        .fix_year  (b_year),
        .bad       (b_bad)
    );

    dd_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign accept = start && !busy;

    // Walk-side helpers: month length, days left in month plus one, jump size for the level.
    assign at_jan1    = (d_reg == DAY_W'(1)) && (m_reg == MONTH_W'(1));
    assign leap       = (y_reg[1:0] == 2'b00);
    assign month_len  = days_in_month(m_reg, leap);
    assign month_room = {1'b0, month_len} - {1'b0, d_reg} + 6'd1;

    always_comb
    begin
        unique case (level_reg)
            LV_400:
            begin
                jump_days  = JUMP_W'(DAYS_400Y);
                jump_years = 9'd400;
            end
            LV_40:
            begin
                jump_days  = JUMP_W'(DAYS_40Y);
                jump_years = 9'd40;
            end
            LV_4:
            begin
                jump_days  = JUMP_W'(DAYS_4Y);
                jump_years = 9'd4;
            end
            LV_1:
            begin
                jump_days  = leap ? JUMP_W'(DAYS_LEAP) : JUMP_W'(DAYS_YEAR);
                jump_years = 9'd1;
            end
            default:
            begin
                jump_days  = '0;
                jump_years = 9'd1;
            end
        endcase
    end

    // Year adder: jump size on a jump step, one on a December rollover.
    assign y_sum  = y_reg + ((at_jan1 && level_reg != LV_MONTH) ? YR_W'(jump_years) : YR_W'(1));
    assign y_over = (32'(y_sum) > 32'(MAX_YEAR));

    // Difference terms: step bit 2 picks date B, which is subtracted.
    assign t_day   = step_reg[2] ? bd_reg : d_reg;
    assign t_month = step_reg[2] ? bm_reg : m_reg;
    assign t_year  = step_reg[2] ? YR_W'(by_reg) : y_reg;

    always_comb
    begin
        case (step_reg[1:0])
            2'd0:    term = ACC_W'(t_year * DAYS_YEAR);
            2'd1:    term = ACC_W'((t_year + 3) >> 2);
            2'd2:    term = ACC_W'(days_before_month(t_month, t_year[1:0] == 2'b00));
            default: term = ACC_W'(t_day);
        endcase
    end

    always_comb
    begin
        alu_req = '{a: '0, b: '0, sub: 1'b0};
        unique case (state_reg)
            ST_DIFF:
            begin
                alu_req.a   = acc_reg;
                alu_req.b   = term;
                alu_req.sub = step_reg[2];
            end
            ST_ADD:
            begin
                alu_req.a   = ACC_W'(left_reg);
                alu_req.b   = (at_jan1 && level_reg != LV_MONTH) ? ACC_W'(jump_days)
                                                                 : ACC_W'(month_room);
                alu_req.sub = 1'b1;
            end
            ST_FIN:
            begin
                // Negate the accumulator for the magnitude.
                alu_req.b   = acc_reg;
                alu_req.sub = 1'b1;
            end
            default:
            begin
                alu_req = '{a: '0, b: '0, sub: 1'b0};
            end
        endcase
    end

    assign magnitude = acc_reg[ACC_W-1] ? alu_rsp.sum : acc_reg;

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        level_next  = level_reg;
        mode_next   = mode_reg;
        err_next    = err_reg;
        ovf_next    = ovf_reg;
        d_next      = d_reg;
        m_next      = m_reg;
        y_next      = y_reg;
        bd_next     = bd_reg;
        bm_next     = bm_reg;
        by_next     = by_reg;
        left_next   = left_reg;
        acc_next    = acc_reg;
        step_next   = step_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // Latch the cleaned dates; date B only counts in mode 0.
                    mode_next  = req.mode;
                    err_next   = a_bad | (~req.mode & b_bad);
                    ovf_next   = 1'b0;
                    d_next     = a_day;
                    m_next     = a_month;
                    y_next     = YR_W'(a_year);
                    bd_next    = b_day;
                    bm_next    = b_month;
                    by_next    = b_year;
                    left_next  = req.day_count;
                    acc_next   = '0;
                    step_next  = '0;
                    level_next = LV_400;
                    state_next = req.mode ? ST_ADD : ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                acc_next  = alu_rsp.sum;
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd7)
                    state_next = ST_FIN;
            end
            ST_ADD:
            begin
                if (at_jan1 && level_reg != LV_MONTH)
                begin
                    // Take the jump if the count covers it and the year stays in range,
                    // otherwise drop to the next smaller jump.
                    if (!alu_rsp.borrow && !y_over)
                    begin
                        left_next = alu_rsp.sum[COUNT_W-1:0];
                        y_next    = y_sum;
                    end
                    else
                    begin
                        unique case (level_reg)
                            LV_400:  level_next = LV_40;
                            LV_40:   level_next = LV_4;
                            LV_4:    level_next = LV_1;
                            default: level_next = LV_MONTH;
                        endcase
                    end
                end
                else if (alu_rsp.borrow)
                begin
                    // Remaining count fits in this month.
                    d_next     = d_reg + left_reg[DAY_W-1:0];
                    state_next = ST_FIN;
                end
                else
                begin
                    left_next = alu_rsp.sum[COUNT_W-1:0];
                    d_next    = DAY_W'(1);
                    if (m_reg == MONTH_W'(12))
                    begin
                        m_next = MONTH_W'(1);
                        y_next = y_sum;
                        if (y_over)
                        begin
                            ovf_next   = 1'b1;
                            state_next = ST_FIN;
                        end
                    end
                    else
                    begin
                        m_next = m_reg + MONTH_W'(1);
                    end
                end
            end
            ST_FIN:
            begin
                result_next.date_error = err_reg;
                if (mode_reg)
                begin
                    result_next.day_difference = '0;
                    result_next.year_overflow  = ovf_reg;
                    if (ovf_reg)
                    begin
                        result_next.result_day   = DAY_W'(31);
                        result_next.result_month = MONTH_W'(12);
                        result_next.result_year  = YEAR_W'(MAX_YEAR);
                    end
                    else
                    begin
                        result_next.result_day   = d_reg;
                        result_next.result_month = m_reg;
                        result_next.result_year  = YEAR_W'(y_reg);
                    end
                end
                else
                begin
                    result_next.day_difference = (magnitude[ACC_W-1:DIFF_W] != '0)
                                               ? DIFF_MAX : magnitude[DIFF_W-1:0];
                    result_next.result_day     = '0;
                    result_next.result_month   = '0;
                    result_next.result_year    = '0;
                    result_next.year_overflow  = 1'b0;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        level_reg  <= level_next;
        mode_reg   <= mode_next;
        err_reg    <= err_next;
        ovf_reg    <= ovf_next;
        d_reg      <= d_next;
        m_reg      <= m_next;
        y_reg      <= y_next;
        bd_reg     <= bd_next;
        bm_reg     <= bm_next;
        by_reg     <= by_next;
        left_reg   <= left_next;
        acc_reg    <= acc_next;
        step_reg   <= step_next;
    end

endmodule

FILE: design/dd_alu.sv
// Shared add/subtract unit of the date block.
// Depends on dd_pkg (alu_req_t, alu_rsp_t).
module dd_alu (
    input  dd_pkg::alu_req_t req,
    output dd_pkg::alu_rsp_t rsp
);
    import dd_pkg::*;

    logic [ACC_W:0] full;

    // Borrow is the inverted carry of an unsigned subtract.
    assign full       = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + (ACC_W+1)'(req.sub);
    assign rsp.sum    = full[ACC_W-1:0];
    assign rsp.borrow = req.sub & ~full[ACC_W];

endmodule

FILE: design/dd_check.sv
// Date validation: flag a bad date and substitute 1.1 of the default year.
// Depends on dd_pkg (days_in_month, field widths).
module dd_check #(
    parameter int MAX_YEAR     = 9999,
    parameter int DEFAULT_YEAR = 2002
) (
    input  logic [dd_pkg::DAY_W-1:0]   day,
    input  logic [dd_pkg::MONTH_W-1:0] month,
    input  logic [dd_pkg::YEAR_W-1:0]  year,
    output logic [dd_pkg::DAY_W-1:0]   fix_day,
    output logic [dd_pkg::MONTH_W-1:0] fix_month,
    output logic [dd_pkg::YEAR_W-1:0]  fix_year,
    output logic                       bad
);
    import dd_pkg::*;

    assign bad = (32'(year) > 32'(MAX_YEAR)) || (day == '0)
               || (day > days_in_month(month, year[1:0] == 2'b00));

    assign fix_day   = bad ? DAY_W'(1)   : day;
    assign fix_month = bad ? MONTH_W'(1) : month;
    assign fix_year  = bad ? YEAR_W'(DEFAULT_YEAR) : year;

endmodule

FILE: design/dd_checker.sv
// Port-level checker for the date block, bound to the top level.
// Depends on dd_pkg (out_t) and date_difference_and_add_days_core.
module dd_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         start,
    input logic         busy,
    input logic         done,
    input dd_pkg::out_t result
);
    import dd_pkg::*;

    // A result word is shown only once the block is free again.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while busy");

    // An accepted word keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // Strobe lasts one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // Overflow only in add mode, which reports no difference.
    a_ovf_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.year_overflow) |-> (result.day_difference == '0))
        else $error("overflow with a nonzero difference");

    // Difference mode leaves the date fields at zero.
    a_diff_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.day_difference != '0) |-> (result.result_month == '0))
        else $error("difference result with a date");

endmodule

bind date_difference_and_add_days_core dd_checker u_dd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

FILE: tb/tb_top.sv
// Testbench for date_difference_and_add_days_core: directed and random date requests, with
// each result word predicted by a small scoreboard class and compared field by field.
// Depends on dd_pkg and on the design files under design/.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     MAX_YEAR     = 9999;
    localparam int     DEFAULT_YEAR = 2002;
    localparam logic   MODE_DIFF    = 1'b0;
    localparam logic   MODE_ADD     = 1'b1;
    localparam int     RANDOM_WORDS = 1630;
    localparam int     IDLE_PCT     = 8;
    localparam int     QUIET_FIRST  = 700;   // random words in this window never idle
    localparam int     QUIET_LAST   = 1000;
    localparam int     DRAIN_CYCLES = 100;   // watch for stray results after the last word
    localparam int     CYCLE_LIMIT  = 600000;
    localparam int     MAX_REPORTS  = 10;
    localparam int     DAYS_4Y      = 1461;

    // Scoreboard: predicts the result word of every accepted request and checks the
    // words that come out, oldest first.
    class date_scoreboard;
        dd_pkg::out_t pending_results[$];
        int           mismatches;
        int           checked;
        int           diff_words;
        int           add_words;
        int           replaced_dates;
        int           overflows;

        static function int month_len(int m, int y);
            case (m)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return (y % 4 == 0) ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        static function bit date_valid(int d, int m, int y);
            return y <= MAX_YEAR && d >= 1 && d <= month_len(m, y);
        endfunction

        // Day number counted from 1 January of year 0.
        static function int day_number(int d, int m, int y);
            int n;
            n = y * 365 + (y + 3) / 4;
            for (int k = 1; k < m; k++)
                n += month_len(k, y);
            return n + d;
        endfunction

        static function dd_pkg::out_t predict_date(dd_pkg::in_t w);
            dd_pkg::out_t r;
            int ad, am, ay, bd, bm, by;
            int na, nb, left, room, year_len;
            bit ovf, finished;
            r = '0;
            ad = w.first_day;
            am = w.first_month;
            ay = w.first_year;
            if (!date_valid(ad, am, ay)) begin
                ad = 1;
                am = 1;
                ay = DEFAULT_YEAR;
                r.date_error = 1'b1;
            end
            if (w.mode == MODE_DIFF) begin
                bd = w.second_day;
                bm = w.second_month;
                by = w.second_year;
                if (!date_valid(bd, bm, by)) begin
                    bd = 1;
                    bm = 1;
                    by = DEFAULT_YEAR;
                    r.date_error = 1'b1;
                end
                na = day_number(ad, am, ay);
                nb = day_number(bd, bm, by);
                // Valid dates stay below the 22-bit ceiling, so no saturation shows up here.
                r.day_difference = 22'(na > nb ? na - nb : nb - na);
            end else begin
                left     = w.day_count;
                ovf      = 1'b0;
                finished = 1'b0;
                // Walk month by month; from a 1 January, skip whole years (four at a time
                // where the year range allows), which lands on the same date as the walk.
                while (!finished && !ovf) begin
                    year_len = (ay % 4 == 0) ? 366 : 365;
                    if (ad == 1 && am == 1 && ay + 4 <= MAX_YEAR && left >= DAYS_4Y) begin
                        left -= DAYS_4Y;
                        ay   += 4;
                    end else if (ad == 1 && am == 1 && left >= year_len) begin
                        left -= year_len;
                        ay++;
                        ovf = ay > MAX_YEAR;
                    end else begin
                        room = month_len(am, ay) - ad;
                        if (room >= left) begin
                            ad += left;
                            finished = 1'b1;
                        end else begin
                            left -= room + 1;
                            ad = 1;
                            if (am == 12) begin
                                am = 1;
                                ay++;
                                ovf = ay > MAX_YEAR;
                            end else begin
                                am++;
                            end
                        end
                    end
                end
                if (ovf) begin
                    ad = 31;
                    am = 12;
                    ay = MAX_YEAR;
                end
                r.result_day    = 5'(ad);
                r.result_month  = 4'(am);
                r.result_year   = 14'(ay);
                r.year_overflow = ovf;
            end
            return r;
        endfunction

        function void note_request(dd_pkg::in_t w);
            dd_pkg::out_t p;
            p = predict_date(w);
            pending_results.push_back(p);
            if (w.mode == MODE_DIFF)
                diff_words++;
            else
                add_words++;
            if (p.date_error)
                replaced_dates++;
            if (p.year_overflow)
                overflows++;
        endfunction

        function void check_result(dd_pkg::out_t got);
            dd_pkg::out_t want;
            checked++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $write("ERROR: result word with no request outstanding: diff=%0d ",
                           got.day_difference);
                    $display("date=%0d.%0d.%0d err=%0b ovf=%0b", got.result_day,
                             got.result_month, got.result_year, got.date_error,
                             got.year_overflow);
                end
                return;
            end
            want = pending_results.pop_front();
            if (got.day_difference !== want.day_difference ||
                got.result_day     !== want.result_day     ||
                got.result_month   !== want.result_month   ||
                got.result_year    !== want.result_year    ||
                got.date_error     !== want.date_error     ||
                got.year_overflow  !== want.year_overflow) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $write("ERROR: word %0d expected diff=%0d date=%0d.%0d.%0d err=%0b ovf=%0b",
                           checked, want.day_difference, want.result_day,
                           want.result_month, want.result_year, want.date_error,
                           want.year_overflow);
                    $display(", got diff=%0d date=%0d.%0d.%0d err=%0b ovf=%0b",
                             got.day_difference, got.result_day, got.result_month,
                             got.result_year, got.date_error, got.year_overflow);
                end
            end
        endfunction
    endclass

    logic          clk   = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    dd_pkg::in_t   req   = '0;
    logic          busy;
    logic          done;
    dd_pkg::out_t  result;

    date_scoreboard sb;
    int             cycles = 0;
    bit             idle_on = 1'b1;

    date_difference_and_add_days_core #(
        .MAX_YEAR     (MAX_YEAR),
        .DEFAULT_YEAR (DEFAULT_YEAR)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req    (req),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watch both sides at the rising edge: check the result first, since a new word
    // accepted in the same cycle lands behind it in the queue.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done)
                sb.check_result(result);
            if (start && !busy)
                sb.note_request(req);
        end
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles, %0d words outstanding", cycles,
                     sb.pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic dd_pkg::in_t make_word(logic mode, int ad, int am, int ay,
                                              int bd, int bm, int by, int count);
        dd_pkg::in_t w;
        w.mode         = mode;
        w.first_day    = 5'(ad);
        w.first_month  = 4'(am);
        w.first_year   = 14'(ay);
        w.second_day   = 5'(bd);
        w.second_month = 4'(bm);
        w.second_year  = 14'(by);
        w.day_count    = 20'(count);
        return w;
    endfunction

    // Mostly valid dates, a fair share on the last day of a month, the rest raw bits.
    function automatic void random_date(output int d, output int m, output int y);
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            d = $urandom_range(31);
            m = $urandom_range(15);
            y = $urandom_range(16383);
        end else begin
            y = (pick < 20) ? (($urandom_range(1) == 0) ? 0 : MAX_YEAR)
                            : $urandom_range(MAX_YEAR);
            m = $urandom_range(1, 12);
            d = (pick < 35) ? date_scoreboard::month_len(m, y)
                            : $urandom_range(1, date_scoreboard::month_len(m, y));
        end
    endfunction

    function automatic dd_pkg::in_t random_word();
        int ad, am, ay, bd, bm, by, count, pick;
        random_date(ad, am, ay);
        random_date(bd, bm, by);
        pick = $urandom_range(9);
        if (pick < 4)
            count = $urandom_range(400);
        else if (pick < 7)
            count = $urandom_range(20000);
        else
            count = $urandom_range(20'hFFFFF);
        return make_word($urandom_range(1) ? MODE_ADD : MODE_DIFF, ad, am, ay, bd, bm, by,
                         count);
    endfunction

    // Present one word from a falling edge, hold it until the block takes it, then
    // leave start low for a random stretch now and then.
    task automatic send_word(input dd_pkg::in_t w);
        start <= 1'b1;
        req   <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        if (idle_on && $urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40))
                @(negedge clk);
        end
    endtask

    initial
    begin
        int drain;
        sb = new();
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words: extremes, leap handling, invalid dates, rollovers, overflow.
        send_word(make_word(MODE_DIFF, 15, 6, 2024, 15, 6, 2024, 0));
        send_word(make_word(MODE_DIFF, 1, 1, 0, 31, 12, MAX_YEAR, 0));
        send_word(make_word(MODE_DIFF, 31, 12, MAX_YEAR, 1, 1, 0, 20'hFFFFF));
        send_word(make_word(MODE_DIFF, 29, 2, 0, 1, 3, 0, 0));           // year zero is leap
        send_word(make_word(MODE_DIFF, 29, 2, 2001, 1, 1, 2002, 0));     // A replaced
        send_word(make_word(MODE_DIFF, 1, 1, 2000, 31, 4, 2000, 0));     // B replaced
        send_word(make_word(MODE_DIFF, 0, 13, 16383, 31, 15, 10000, 0)); // both replaced
        send_word(make_word(MODE_DIFF, 31, 12, 1999, 1, 1, 2000, 0));
        send_word(make_word(MODE_DIFF, 10, 10, 1234, 1, 1, MAX_YEAR + 1, 0));
        send_word(make_word(MODE_DIFF, 31, 1, 5, 30, 11, 8191, 0));
        send_word(make_word(MODE_DIFF, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(MODE_ADD, 1, 1, 2000, 0, 0, 0, 0));
        send_word(make_word(MODE_ADD, 28, 2, 2001, 1, 1, 1, 1));
        send_word(make_word(MODE_ADD, 28, 2, 2004, 1, 1, 1, 1));
        send_word(make_word(MODE_ADD, 31, 12, 1999, 1, 1, 1, 1));
        send_word(make_word(MODE_ADD, 1, 1, 0, 31, 15, 16383, 20'hFFFFF));
        send_word(make_word(MODE_ADD, 31, 12, MAX_YEAR, 1, 1, 1, 1));     // overflow by a day
        send_word(make_word(MODE_ADD, 1, 1, 9990, 1, 1, 1, 20'hFFFFF));
        send_word(make_word(MODE_ADD, 0, 0, 0, 1, 1, 1, 10));            // A replaced
        send_word(make_word(MODE_ADD, 5, 5, 2005, 0, 13, 16383, 100));   // bad B is ignored
        send_word(make_word(MODE_ADD, 31, 1, 2003, 1, 1, 1, 29));
        send_word(make_word(MODE_ADD, 1, 1, 9996, 1, 1, 1, DAYS_4Y - 1)); // last day exactly
        send_word(make_word(MODE_ADD, 1, 1, 9996, 1, 1, 1, DAYS_4Y));     // one past the end
        send_word(make_word(MODE_ADD, 15, 7, 2500, 1, 1, 1, 365));

        // Random words, with a quiet window where start never drops between words.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            idle_on = !(i >= QUIET_FIRST && i < QUIET_LAST);
            send_word(random_word());
        end
        start <= 1'b0;

        // Drain: wait for every predicted word, then watch a while for stray results.
        drain = 0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        while (drain < DRAIN_CYCLES) begin
            @(posedge clk);
            drain++;
        end
        sb.mismatches += sb.pending_results.size();

        $write("Ran %0d day-difference and %0d add-days requests, ", sb.diff_words,
               sb.add_words);
        $display("%0d with a replaced date and %0d with year overflow.",
                 sb.replaced_dates, sb.overflows);
        $display("Checked %0d result words in %0d cycles, %0d failures.", sb.checked, cycles,
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
